// ===== sv/src_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_pkg
// Types shared by the route cache top level and scan engine.
// ----------------------------------------------------------------------------
package src_pkg;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] current_frame;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] dest_x;
		logic [15:0] dest_y;
		logic [15:0] route_tag;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        reversed;
		logic [15:0] found_tag;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] frame;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [31:0] last_use;
		logic [15:0] tag;
	} entry_t;

endpackage
`default_nettype wire

// ===== sv/symmetric_route_cache_lru.sv =====
`default_nettype none
// An insert with room, or a lookup on an empty cache, is answered as the engine pops it from the queue.
// Any other lookup scans the entries until a match or the last valid one; a full insert scans every slot.
// The engine takes a new command only once it has queued the result of the last one, and it holds
// while the result queue is full; the scan reads the entry memory one entry per cycle.
// Reset clears the queues, the engine state and the entry count; entry storage is not cleared.
// ----------------------------------------------------------------------------
// symmetric_route_cache_lru
// Fully associative route cache keyed by a start and destination point pair,
// matched in either direction, with least-recently-used replacement.
// ----------------------------------------------------------------------------
module symmetric_route_cache_lru #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire src_pkg::req_t req,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output src_pkg::rsp_t      rsp
);

	import src_pkg::*;

	cmd_t in_cmd;
	cmd_t q_cmd;
	logic q_empty;
	logic q_pop;

	always_comb begin
		in_cmd.op    = op_t'(req.req_type);
		in_cmd.frame = req.current_frame;
		in_cmd.sx    = req.start_x;
		in_cmd.sy    = req.start_y;
		in_cmd.dx    = req.dest_x;
		in_cmd.dy    = req.dest_y;
		in_cmd.tag   = req.route_tag;
	end

	src_queue #(
		.WIDTH($bits(cmd_t))
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_cmd),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	src_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== sv/src_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_queue
// Two-entry first-in first-out queue that decouples producer and consumer.
// ----------------------------------------------------------------------------
module src_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/src_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// src_back
// Scan engine: holds the entry memory, scans it one entry per cycle for
// lookups and for the oldest entry on a full insert, and queues results.
// ----------------------------------------------------------------------------
module src_back #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_empty,
	input  wire src_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  wire logic          pop,
	output src_pkg::rsp_t      rsp
);

	import src_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   min_idx_q;
	logic [31:0]        min_use_q;
	entry_t             mem [CAPACITY];
	entry_t             rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               we;
	logic [IDX_W-1:0]   wa;
	entry_t             wd;
	logic               res_push;
	rsp_t               res;
	logic               res_full;
	logic               is_full;
	logic               fwd_match;
	logic               rev_match;
	logic               last_valid;
	logic               last_slot;
	logic               better;
	logic [IDX_W-1:0]   victim;
	entry_t             new_entry;

	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign fwd_match  = (rd_data_q.sx == cmd_q.sx) && (rd_data_q.sy == cmd_q.sy) &&
	                    (rd_data_q.dx == cmd_q.dx) && (rd_data_q.dy == cmd_q.dy);
	assign rev_match  = (rd_data_q.sx == cmd_q.dx) && (rd_data_q.sy == cmd_q.dy) &&
	                    (rd_data_q.dx == cmd_q.sx) && (rd_data_q.dy == cmd_q.sy);
	assign last_valid = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign last_slot  = (idx_q == IDX_W'(CAPACITY - 1));
	assign better     = (idx_q == '0) || (rd_data_q.last_use < min_use_q);
	assign victim     = better ? idx_q : min_idx_q;

	always_comb begin
		new_entry.sx       = cmd.sx;
		new_entry.sy       = cmd.sy;
		new_entry.dx       = cmd.dx;
		new_entry.dy       = cmd.dy;
		new_entry.last_use = cmd.frame;
		new_entry.tag      = cmd.tag;
		cmd_pop  = 1'b0;
		we       = 1'b0;
		wa       = '0;
		wd       = new_entry;
		res_push = 1'b0;
		res      = '0;
		rd_addr  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_INSERT && !is_full) begin
						we       = 1'b1;
						wa       = count_q[IDX_W-1:0];
						res_push = 1'b1;
					end else if (cmd.op == OP_LOOKUP && count_q == '0) begin
						res_push = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				rd_addr = last_slot ? '0 : idx_q + IDX_W'(1);
				wd.sx       = cmd_q.sx;
				wd.sy       = cmd_q.sy;
				wd.dx       = cmd_q.dx;
				wd.dy       = cmd_q.dy;
				wd.last_use = cmd_q.frame;
				wd.tag      = cmd_q.tag;
				if (cmd_q.op == OP_LOOKUP) begin
					if (fwd_match || rev_match) begin
						we            = 1'b1;
						wa            = idx_q;
						wd            = rd_data_q;
						wd.last_use   = cmd_q.frame;
						res_push      = 1'b1;
						res.hit       = 1'b1;
						res.reversed  = !fwd_match;
						res.found_tag = rd_data_q.tag;
					end else if (last_valid) begin
						res_push = 1'b1;
					end
				end else if (last_slot) begin
					we       = 1'b1;
					wa       = victim;
					res_push = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SCAN && cmd_q.op == OP_INSERT && better) begin
			min_use_q <= rd_data_q.last_use;
			min_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd_pop) begin
						if (cmd.op == OP_INSERT && !is_full) begin
							count_q <= count_q + CNT_W'(1);
						end else if (!res_push) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	src_queue #(
		.WIDTH($bits(rsp_t))
	) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (rsp),
		.empty  (empty)
	);

endmodule
`default_nettype wire
